/* src/arlc_pkg.sv */
// Shared types and constants of the adaptive redundancy level controller.
package arlc_pkg;

   localparam int RING_DEPTH = 64;
   localparam int TAG_W      = $clog2(RING_DEPTH);
   localparam int WINDOW     = 16;
   localparam int WIN_W      = $clog2(WINDOW);
   localparam int BOUND_W    = WIN_W + 1;
   localparam int MAX_CH     = 8;
   localparam int LANE_W     = $clog2(MAX_CH);
   localparam int CH_W       = 4;
   localparam int ROOT_W     = 3;
   localparam int LIMIT_W    = 32;
   localparam int TIME_W     = 48;
   localparam int SUM_W      = TIME_W + WIN_W;
   localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0]  MIN_RTT_RESET  = TIME_W'(999999999);
   localparam logic [CH_W-1:0]    CHANNEL_RESET  = CH_W'(3);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET    = LIMIT_W'(100);

   localparam logic OP_ISSUE    = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_CHANNEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUEST_LIMIT = 2'd2;

   localparam logic [1:0] EV_ISSUE     = 2'd0;
   localparam logic [1:0] EV_NEW       = 2'd1;
   localparam logic [1:0] EV_DUPLICATE = 2'd2;

   typedef struct packed {
      logic              operation;
      logic [TIME_W-1:0] now_ns;
      logic [5:0]        response_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]        event_kind;
      logic [5:0]        request_tag;
      logic [7:0]        channel_mask;
      logic              more_to_send;
      logic [TIME_W-1:0] rtt_ns;
      logic [TIME_W-1:0] average_rtt_ns;
      logic [TIME_W-1:0] min_rtt_ns;
      logic [3:0]        redundancy_level;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic root_step;
      logic lane_step;
      logic lookup;
      logic measure;
      logic sum_step;
      logic div_start;
      logic div_step;
      logic scale;
      logic adjust;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic root_ok;
      logic lanes_done;
      logic duplicate;
      logic sum_done;
      logic div_done;
   } sts_type;

endpackage

/* src/arlc_ctrl.sv */
// Sequencing state machine of the adaptive redundancy level controller.
module arlc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_operation,
   output logic              busy,
   output logic              rsp_valid,
   output arlc_pkg::cmd_type cmd,
   input  arlc_pkg::sts_type sts
);
   import arlc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ISSUE,
      S_ROOT,
      S_LANE,
      S_LOOKUP,
      S_MEASURE,
      S_SUM,
      S_DIV,
      S_SCALE,
      S_ADJUST,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_operation == OP_RESPONSE) ? S_LOOKUP : S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = S_ROOT;
         end
         S_ROOT: begin
            if (sts.root_ok) state_in = S_LANE;
            else cmd.root_step = 1'b1;
         end
         S_LANE: begin
            if (sts.lanes_done) state_in = S_EMIT;
            else cmd.lane_step = 1'b1;
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = sts.duplicate ? S_EMIT : S_MEASURE;
         end
         S_MEASURE: begin
            cmd.measure = 1'b1;
            state_in    = S_SUM;
         end
         S_SUM: begin
            if (sts.sum_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.sum_step = 1'b1;
            end
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_SCALE;
            else cmd.div_step = 1'b1;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_ADJUST;
         end
         S_ADJUST: begin
            cmd.adjust = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (state_ff == S_EMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/arlc_datapath.sv */
// Registers, ring memory, window accumulator and divider of the controller.
module arlc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  arlc_pkg::req_type                   req_data,
   output arlc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [arlc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [arlc_pkg::CSR_DATA_W-1:0]     csr_data,
   input  arlc_pkg::cmd_type                   cmd,
   output arlc_pkg::sts_type                   sts
);
   import arlc_pkg::*;

   logic [CH_W-1:0]    chan_cnt_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic               op_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [TAG_W-1:0]   tag_ff;

   logic [RING_DEPTH-1:0] flags_ff;
   logic [TIME_W-1:0]     times_mem [RING_DEPTH];
   logic [TIME_W-1:0]     rd_ff;
   logic [TIME_W-1:0]     window_ff [WINDOW];
   logic [TIME_W-1:0]     min_ff;
   logic [CH_W-1:0]       level_ff;
   logic [LIMIT_W-1:0]    sent_ff;

   logic [TAG_W-1:0]   slot_out_ff;
   logic               more_ff;
   logic [CH_W-1:0]    r_ff;
   logic [CH_W-1:0]    lane_ff;
   logic [MAX_CH-1:0]  mask_ff;
   logic               dup_ff;

   logic [TIME_W-1:0]    rtt_ff;
   logic [BOUND_W-1:0]   bound_ff;
   logic [BOUND_W-1:0]   idx_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SUM_W-1:0]     quo_ff;
   logic [BOUND_W-1:0]   rem_ff;
   logic [DIV_CNT_W-1:0] dcnt_ff;
   logic [TIME_W-1:0]    avg_ff;
   logic [TIME_W-1:0]    diff_ff;
   logic                 gt_ff;
   logic                 lt_ff;

   logic [CH_W-1:0]    cc;
   logic [TAG_W-1:0]   slot;
   logic [LIMIT_W-1:0] sent_next;
   logic [CH_W-1:0]    r_inc;
   logic [TIME_W-1:0]  rtt_w;
   logic [BOUND_W:0]   rem_sh;
   logic               q_bit;
   logic [TIME_W-1:0]  avg_w;
   logic [SUM_W-1:0]   min_ext;
   logic [SUM_W-1:0]   ten_d;
   logic [SUM_W-1:0]   ten_d1;
   logic               over;
   logic               under;

   always_comb begin
      if (chan_cnt_ff == '0) cc = CH_W'(1);
      else if (chan_cnt_ff > CH_W'(MAX_CH)) cc = CH_W'(MAX_CH);
      else cc = chan_cnt_ff;
   end

   assign slot      = sent_ff[TAG_W-1:0];
   assign sent_next = sent_ff + LIMIT_W'(1);
   assign r_inc     = r_ff + CH_W'(1);
   assign rtt_w     = now_ff - rd_ff;
   assign rem_sh    = {rem_ff, quo_ff[SUM_W-1]};
   assign q_bit     = (rem_sh >= {1'b0, bound_ff});
   assign avg_w     = quo_ff[TIME_W-1:0];
   assign min_ext   = {{(SUM_W-TIME_W){1'b0}}, min_ff};
   assign ten_d     = ({{(SUM_W-TIME_W){1'b0}}, diff_ff} << 3)
                    + ({{(SUM_W-TIME_W){1'b0}}, diff_ff} << 1);
   assign ten_d1    = ten_d + SUM_W'(10);
   assign over      = gt_ff && (ten_d > min_ext);
   assign under     = lt_ff || (ten_d1 <= min_ext);

   always_comb begin
      sts.root_ok    = (r_ff < cc);
      sts.lanes_done = (lane_ff == cc);
      sts.duplicate  = flags_ff[tag_ff];
      sts.sum_done   = (idx_ff == bound_ff);
      sts.div_done   = (dcnt_ff == DIV_CNT_W'(SUM_W));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cnt_ff <= CHANNEL_RESET;
         root_ff     <= '0;
         limit_ff    <= LIMIT_RESET;
         flags_ff    <= '1;
         min_ff      <= MIN_RTT_RESET;
         level_ff    <= CHANNEL_RESET;
         sent_ff     <= '0;
         for (int i = 0; i < WINDOW; i++) window_ff[i] <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CHANNEL_COUNT: chan_cnt_ff <= csr_data[CH_W-1:0];
               CSR_ROOT_CHANNEL:  root_ff     <= csr_data[ROOT_W-1:0];
               CSR_REQUEST_LIMIT: limit_ff    <= csr_data[LIMIT_W-1:0];
               default:           chan_cnt_ff <= chan_cnt_ff;
            endcase
         end
         if (cmd.issue) begin
            flags_ff[slot] <= 1'b0;
            sent_ff        <= sent_next;
         end
         if (cmd.measure) begin
            flags_ff[tag_ff]                <= 1'b1;
            window_ff[tag_ff[WIN_W-1:0]]    <= rtt_w;
            if (rtt_w < min_ff) min_ff <= rtt_w;
         end
         if (cmd.adjust) begin
            if (over && (level_ff > CH_W'(1))) level_ff <= level_ff - CH_W'(1);
            else if (under && (level_ff < cc)) level_ff <= level_ff + CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= times_mem[tag_ff];
      if (cmd.issue) times_mem[slot] <= now_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.operation;
         now_ff <= req_data.now_ns;
         tag_ff <= req_data.response_tag[TAG_W-1:0];
         dup_ff <= 1'b0;
      end
      if (cmd.issue) begin
         slot_out_ff <= slot;
         more_ff     <= (sent_next < limit_ff);
         r_ff        <= {1'b0, root_ff};
         lane_ff     <= '0;
         mask_ff     <= '0;
      end
      if (cmd.root_step) r_ff <= r_ff - cc;
      if (cmd.lane_step) begin
         mask_ff[lane_ff[LANE_W-1:0]] <= (r_ff < level_ff);
         lane_ff                      <= lane_ff + CH_W'(1);
         r_ff                         <= (r_inc == cc) ? '0 : r_inc;
      end
      if (cmd.lookup) dup_ff <= flags_ff[tag_ff];
      if (cmd.measure) begin
         rtt_ff   <= rtt_w;
         bound_ff <= (tag_ff < TAG_W'(WINDOW)) ? BOUND_W'(tag_ff) + BOUND_W'(1)
                                                : BOUND_W'(WINDOW);
         sum_ff   <= '0;
         idx_ff   <= '0;
      end
      if (cmd.sum_step) begin
         sum_ff <= sum_ff + {{(SUM_W-TIME_W){1'b0}}, window_ff[idx_ff[WIN_W-1:0]]};
         idx_ff <= idx_ff + BOUND_W'(1);
      end
      if (cmd.div_start) begin
         quo_ff  <= sum_ff;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= q_bit ? BOUND_W'(rem_sh - {1'b0, bound_ff}) : rem_sh[BOUND_W-1:0];
         quo_ff  <= {quo_ff[SUM_W-2:0], q_bit};
         dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.scale) begin
         avg_ff  <= avg_w;
         gt_ff   <= (avg_w > min_ff);
         lt_ff   <= (avg_w < min_ff);
         diff_ff <= avg_w - min_ff;
      end
      if (cmd.emit) begin
         if (op_ff == OP_ISSUE) begin
            rsp_data.event_kind     <= EV_ISSUE;
            rsp_data.request_tag    <= 6'(slot_out_ff);
            rsp_data.channel_mask   <= 8'(mask_ff);
            rsp_data.more_to_send   <= more_ff;
            rsp_data.rtt_ns         <= '0;
            rsp_data.average_rtt_ns <= '0;
         end else begin
            rsp_data.event_kind     <= dup_ff ? EV_DUPLICATE : EV_NEW;
            rsp_data.request_tag    <= '0;
            rsp_data.channel_mask   <= '0;
            rsp_data.more_to_send   <= 1'b0;
            rsp_data.rtt_ns         <= dup_ff ? '0 : rtt_ff;
            rsp_data.average_rtt_ns <= dup_ff ? '0 : avg_ff;
         end
         rsp_data.min_rtt_ns       <= min_ff;
         rsp_data.redundancy_level <= level_ff;
      end
   end

endmodule

/* src/adaptive_redundancy_level_control_core.sv */
// Top level of the adaptive redundancy level controller.
//
// Requests enter on req_data when start is high and busy is low. An issue
// request tags the send with the sent count modulo 64, records its time and
// returns the channel mask; a response request checks the tag, measures the
// round trip, averages the RTT window and moves the redundancy level by at most one.
// Each request gives one result on rsp_data, marked by a single-cycle
// rsp_valid; the receiver cannot stall and must take it in that cycle.
// Before the result, an issue request reduces root_channel modulo the channel
// count and sets one mask lane per channel; a new response looks up the tag,
// measures, sums the window (up to 16 entries), divides, scales and adjusts;
// a duplicate response goes from the lookup straight to the result.
// The 52-step bit-serial divider and the window walk set the response time.
// One request is processed at a time; busy covers its whole span.
// The csr channel (always ready) writes channel_count, root_channel and
// request_limit at indexes 0, 1, 2; write only while busy is low.
// Synchronous reset restores the register defaults, marks every ring slot
// answered, clears the window and sets the minimum RTT to 999999999 ns.
module adaptive_redundancy_level_control_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  arlc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output arlc_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [arlc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [arlc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import arlc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   arlc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_data.operation),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd),
      .sts           (sts)
   );

   arlc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

/* tb/testbench.sv */
// Testbench for the adaptive redundancy level controller: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module testbench;
   import arlc_pkg::*;

   localparam int          SLACK_DIVISOR = 10;
   localparam int unsigned LEVEL_RESET   = 3;
   localparam int          CYCLE_LIMIT   = 1500000;
   localparam int          PHASES        = 8;
   localparam int          PHASE_ITEMS   = 250;
   localparam int          OPEN_CAP      = 40;
   localparam int          DONE_CAP      = 8;
   localparam int          PRINT_CAP     = 30;

   class redundancy_scoreboard;
      logic [TIME_W-1:0] issue_time [RING_DEPTH];
      bit                answered   [RING_DEPTH];
      logic [TIME_W-1:0] rtt_hist   [WINDOW];
      logic [TIME_W-1:0] min_rtt;
      int unsigned       level;
      int unsigned       sent;
      int unsigned       chan_reg;
      int unsigned       root_reg;
      int unsigned       limit_reg;
      rsp_type           pending_results [$];
      int                mismatches;

      function new();
         foreach (issue_time[i]) issue_time[i] = '0;
         foreach (answered[i]) answered[i] = 1'b1;
         foreach (rtt_hist[i]) rtt_hist[i] = '0;
         min_rtt    = MIN_RTT_RESET;
         level      = LEVEL_RESET;
         sent       = 0;
         chan_reg   = CHANNEL_RESET;
         root_reg   = 0;
         limit_reg  = LIMIT_RESET;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_CHANNEL_COUNT: chan_reg = value[CH_W-1:0];
            CSR_ROOT_CHANNEL:  root_reg = value[ROOT_W-1:0];
            CSR_REQUEST_LIMIT: limit_reg = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         int unsigned lanes;
         int unsigned slot;
         int unsigned bound;
         logic [63:0] sum;
         logic [63:0] avg;
         logic [63:0] thr;
         e = '0;
         lanes = (chan_reg < 1) ? 1 : ((chan_reg > MAX_CH) ? MAX_CH : chan_reg);
         if (r.operation == OP_ISSUE) begin
            slot = sent % RING_DEPTH;
            issue_time[slot] = r.now_ns;
            answered[slot] = 1'b0;
            sent = sent + 1;
            for (int i = 0; i < lanes; i++) begin
               if (((i + root_reg) % lanes) < level) e.channel_mask[i] = 1'b1;
            end
            e.event_kind   = EV_ISSUE;
            e.request_tag  = TAG_W'(slot);
            e.more_to_send = (sent < limit_reg);
         end else begin
            slot = r.response_tag;
            if (answered[slot]) begin
               e.event_kind = EV_DUPLICATE;
            end else begin
               answered[slot] = 1'b1;
               e.rtt_ns = r.now_ns - issue_time[slot];
               rtt_hist[slot % WINDOW] = e.rtt_ns;
               if (e.rtt_ns < min_rtt) min_rtt = e.rtt_ns;
               bound = (slot < WINDOW) ? slot + 1 : WINDOW;
               sum = '0;
               for (int i = 0; i < bound; i++) sum = sum + rtt_hist[i];
               avg = sum / bound;
               thr = 64'(min_rtt) + 64'(min_rtt) / SLACK_DIVISOR;
               if (avg > thr && level > 1) level = level - 1;
               else if (avg < thr && level < lanes) level = level + 1;
               e.event_kind     = EV_NEW;
               e.average_rtt_ns = avg[TIME_W-1:0];
            end
         end
         e.min_rtt_ns       = min_rtt;
         e.redundancy_level = level[3:0];
         pending_results.push_back(e);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type e;
         if (pending_results.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            e = pending_results.pop_front();
            if (got.event_kind !== e.event_kind)
               report_mismatch($sformatf("event_kind %0d, want %0d", got.event_kind,
                                         e.event_kind));
            if (got.request_tag !== e.request_tag)
               report_mismatch($sformatf("request_tag %0d, want %0d", got.request_tag,
                                         e.request_tag));
            if (got.channel_mask !== e.channel_mask)
               report_mismatch($sformatf("channel_mask %h, want %h", got.channel_mask,
                                         e.channel_mask));
            if (got.more_to_send !== e.more_to_send)
               report_mismatch($sformatf("more_to_send %b, want %b", got.more_to_send,
                                         e.more_to_send));
            if (got.rtt_ns !== e.rtt_ns)
               report_mismatch($sformatf("rtt_ns %0d, want %0d", got.rtt_ns, e.rtt_ns));
            if (got.average_rtt_ns !== e.average_rtt_ns)
               report_mismatch($sformatf("average_rtt_ns %0d, want %0d", got.average_rtt_ns,
                                         e.average_rtt_ns));
            if (got.min_rtt_ns !== e.min_rtt_ns)
               report_mismatch($sformatf("min_rtt_ns %0d, want %0d", got.min_rtt_ns,
                                         e.min_rtt_ns));
            if (got.redundancy_level !== e.redundancy_level)
               report_mismatch($sformatf("redundancy_level %0d, want %0d",
                                         got.redundancy_level, e.redundancy_level));
         end
      endtask

      task check_drained();
         if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   redundancy_scoreboard tracker = new();

   int                idle_pct = 0;
   int                bad_pct = 0;
   int unsigned       issued_total = 0;
   int                cycles = 0;
   logic [TIME_W-1:0] now_clock = TIME_W'(1000000);
   logic [TIME_W-1:0] sent_at [RING_DEPTH];
   logic [TAG_W-1:0]  open_tags [$];
   logic [TAG_W-1:0]  done_tags [$];

   adaptive_redundancy_level_control_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check_result(rsp_data);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [TIME_W-1:0] rand48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[TIME_W-1:0];
   endfunction

   task automatic send_request(input req_type r);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_request(r);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 90)) @(posedge clock);
      end
   endtask

   task automatic issue_at(input logic [TIME_W-1:0] now);
      req_type          r;
      logic [TAG_W-1:0] tag;
      int               hits [$];
      tag = TAG_W'(issued_total % RING_DEPTH);
      sent_at[tag] = now;
      issued_total++;
      hits = open_tags.find_first_index(x) with (x == tag);
      if (hits.size() != 0) open_tags.delete(hits[0]);
      open_tags.push_back(tag);
      if (open_tags.size() > OPEN_CAP) void'(open_tags.pop_front());
      r.operation    = OP_ISSUE;
      r.now_ns       = now;
      r.response_tag = TAG_W'($urandom);
      send_request(r);
   endtask

   task automatic respond(input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] now);
      req_type r;
      int      hits [$];
      hits = open_tags.find_first_index(x) with (x == tag);
      if (hits.size() != 0) open_tags.delete(hits[0]);
      done_tags.push_back(tag);
      if (done_tags.size() > DONE_CAP) void'(done_tags.pop_front());
      r.operation    = OP_RESPONSE;
      r.now_ns       = now;
      r.response_tag = tag;
      send_request(r);
   endtask

   task automatic random_request();
      int               roll;
      int               pick;
      logic [TAG_W-1:0] tag;
      logic [TIME_W-1:0] rtt;
      roll = $urandom_range(99);
      if (roll < 2) begin
         issue_at(rand48());
      end else if (roll < 4) begin
         respond(TAG_W'($urandom_range(RING_DEPTH - 1)), rand48());
      end else if (roll < 10 && done_tags.size() != 0) begin
         respond(done_tags[$urandom_range(done_tags.size() - 1)], rand48());
      end else if (roll < 55 || open_tags.size() == 0) begin
         now_clock = now_clock + $urandom_range(1, 3000);
         issue_at(now_clock);
      end else begin
         pick = ($urandom_range(3) == 0) ? $urandom_range(open_tags.size() - 1) : 0;
         tag = open_tags[pick];
         if ($urandom_range(99) < bad_pct) rtt = $urandom_range(1200, 4000);
         else rtt = $urandom_range(1000, 1060);
         respond(tag, sent_at[tag] + rtt);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_register(idx, value);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input int p);
      logic [CSR_DATA_W-1:0] chan;
      logic [CSR_DATA_W-1:0] root;
      logic [CSR_DATA_W-1:0] limit;
      int unsigned           chan_list [PHASES] = '{8, 0, 15, 1, 5, 9, 2, 4};
      int unsigned           root_list [PHASES] = '{7, 0, 3, 5, 2, 6, 1, 4};
      chan = ($urandom & ~32'hF) | chan_list[p];
      root = ($urandom & ~32'h7) | root_list[p];
      case (p)
         0:       limit = 32'hFFFF_FFFF;
         1:       limit = 32'h0;
         3:       limit = 32'h1;
         5:       limit = 32'h8000_0000;
         7:       limit = 32'd100;
         default: limit = issued_total + $urandom_range(5, 200);
      endcase
      write_csr(CSR_CHANNEL_COUNT, chan);
      write_csr(CSR_ROOT_CHANNEL, root);
      write_csr(CSR_REQUEST_LIMIT, limit);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      respond(TAG_W'(0), '1);
      respond(TAG_W'(63), '0);
      issue_at(TIME_W'(100));
      respond(TAG_W'(0), TIME_W'(1100));
      issue_at(TIME_W'(2000));
      respond(TAG_W'(1), TIME_W'(3200));
      respond(TAG_W'(1), TIME_W'(3300));
      issue_at(48'hFFFF_FFFF_FF00);
      respond(TAG_W'(2), 48'h300);
      issue_at(TIME_W'(5000));
      respond(TAG_W'(3), TIME_W'(105000));
      issue_at(TIME_W'(6000));
      issue_at('1);
      respond(TAG_W'(5), TIME_W'(999));
      issue_at(TIME_W'(7000));
      respond(TAG_W'(4), TIME_W'(7000));
      respond(TAG_W'(6), TIME_W'(8000));

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         configure(p);
         idle_pct = (p < 3) ? 6 : ((p < 6) ? 65 : 0);
         bad_pct = (p % 2 == 0) ? 2 : 35;
         repeat (PHASE_ITEMS) random_request();
      end

      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      tracker.check_drained();
      if (tracker.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
